### src/bpv_pkg.sv
`default_nettype none
package bpv_pkg;

  // Fixed field widths
  localparam int VAL_W   = 64;
  localparam int WIN_W   = 16;
  localparam int CMD_W   = 2;
  localparam int CFG_I_W = 1;

  // Defaults for the top-level parameters
  localparam int DEF_TABLE_ENTRIES = 64;
  localparam int DEF_COUNT_WIDTH   = 16;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_VOTE    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ABSTAIN = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DECIDE  = 2'd2;

  // Register indexes
  localparam logic [CFG_I_W-1:0] REG_CURRENT = 1'b0;
  localparam logic [CFG_I_W-1:0] REG_TARGET  = 1'b1;

  // Result of one pass through the shared value comparator
  typedef struct packed {
    logic in_range;
    logic key_hit;
    logic tgt_hit;
  } eval_t;

endpackage
`default_nettype wire

### src/bpv_ram.sv
`default_nettype none
module bpv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### src/bpv_eval.sv
`default_nettype none
module bpv_eval (
  input  wire logic [bpv_pkg::VAL_W-1:0] val,
  input  wire logic [bpv_pkg::VAL_W-1:0] key,
  input  wire logic [bpv_pkg::VAL_W-1:0] tgt,
  input  wire logic [bpv_pkg::VAL_W-1:0] lo,
  input  wire logic [bpv_pkg::VAL_W-1:0] hi,
  output bpv_pkg::eval_t                 res
);

  import bpv_pkg::*;

  // Range test, match against the vote being placed, match against target
  always_comb begin
    res.in_range = (val >= lo) && (val <= hi);
    res.key_hit  = (val == key);
    res.tgt_hit  = (val == tgt);
  end

endmodule
`default_nettype wire

### src/bounded_plurality_vote_unit.sv
`default_nettype none
// Bounded plurality vote unit. Votes for 64-bit values are tallied in a table
// of TABLE_ENTRIES entries, each holding a value and a count that saturates at
// 2^COUNT_WIDTH-1. Command 0 votes for vote_value, command 1 votes for the
// current setting, command 2 decides: it returns the most-voted value between
// current and target (inclusive, ties to the smaller value, target always
// holding one implicit vote), its count, a changed flag and a table-overflow
// flag, then empties the table. Command 3 is taken and ignored. Votes outside
// the range are dropped silently; a new value arriving at a full table is
// dropped and flagged. The table sits in one single-port-read RAM walked by a
// small sequencer, one entry at a time, so one item occupies the block until
// it is done and in_tready is low meanwhile. A vote is range-tested, then
// compared with the live entries in turn and bumped on a match, else appended
// or flagged as overflow; a decide folds each entry, then the implicit target
// vote, and waits for out_tready when the previous result has not been taken.
// A waiting result does not block the next vote. The table needs no clearing
// pass: a fill count marks the live entries. Configuration writes are always
// accepted (cfg_ready is high).
module bounded_plurality_vote_unit #(
  parameter int TABLE_ENTRIES = bpv_pkg::DEF_TABLE_ENTRIES,
  parameter int COUNT_WIDTH   = bpv_pkg::DEF_COUNT_WIDTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // in_tdata: vote_value[63:0]
  input  wire logic [63:0]                   in_tdata,
  // in_tuser: command[1:0]
  input  wire logic [bpv_pkg::CMD_W-1:0]     in_tuser,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  // out_tdata: chosen_value[63:0], winning_votes[79:64], changed[80],
  //            table_overflow[81], zero[87:82]
  output logic [87:0]                        out_tdata,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [bpv_pkg::CFG_I_W-1:0]   cfg_index,
  input  wire logic [bpv_pkg::VAL_W-1:0]     cfg_data
);

  import bpv_pkg::*;

  localparam int IDX_W  = $clog2(TABLE_ENTRIES);
  localparam int USED_W = $clog2(TABLE_ENTRIES + 1);
  localparam int ENT_W  = COUNT_WIDTH + VAL_W;
  localparam int WIDE_W = (COUNT_WIDTH > WIN_W) ? COUNT_WIDTH : WIN_W;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
  localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);
  localparam logic [USED_W-1:0]      USED_FULL = USED_W'(TABLE_ENTRIES);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,  // wait for a transfer
    S_CHK  = 9'b000000010,  // range test on the vote
    S_RD   = 9'b000000100,  // issue a table read
    S_VCMP = 9'b000001000,  // vote: compare entry, bump on match
    S_APND = 9'b000010000,  // vote: append a new entry or flag overflow
    S_DCHK = 9'b000100000,  // decide: range and target test on entry
    S_DCON = 9'b001000000,  // decide: fold candidate into best
    S_TGT  = 9'b010000000,  // decide: fold the implicit target vote
    S_FIN  = 9'b100000000   // decide: load the result register
  } state_t;

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
    sat_inc = (c == CNT_MAX) ? c : c + CNT_ONE;
  endfunction

  state_t                  state_r, state_nxt;
  logic [VAL_W-1:0]        cur_r, cur_nxt;
  logic [VAL_W-1:0]        tgt_r, tgt_nxt;
  logic [VAL_W-1:0]        lo_r, lo_nxt;
  logic [VAL_W-1:0]        hi_r, hi_nxt;
  logic [VAL_W-1:0]        vote_r, vote_nxt;
  logic [USED_W-1:0]       used_r, used_nxt;
  logic                    ovf_r, ovf_nxt;
  logic [IDX_W-1:0]        idx_r, idx_nxt;
  logic [VAL_W-1:0]        best_v_r, best_v_nxt;
  logic [COUNT_WIDTH-1:0]  best_c_r, best_c_nxt;
  logic                    seen_r, seen_nxt;
  logic [VAL_W-1:0]        cand_v_r, cand_v_nxt;
  logic [COUNT_WIDTH-1:0]  cand_c_r, cand_c_nxt;
  logic                    cand_ok_r, cand_ok_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [87:0]             out_data_r, out_data_nxt;
  logic                    dec_r, dec_nxt;

  logic                    ram_we;
  logic [IDX_W-1:0]        ram_waddr;
  logic [ENT_W-1:0]        ram_wdata;
  logic [ENT_W-1:0]        ram_rdata;
  logic [VAL_W-1:0]        rd_val;
  logic [COUNT_WIDTH-1:0]  rd_cnt;
  logic [VAL_W-1:0]        eval_val;
  eval_t                   ev;
  logic                    in_xfer;
  logic                    slot_free;
  logic                    more;
  logic                    take;
  logic [WIDE_W-1:0]       best_wide;
  logic [WIN_W-1:0]        win_cnt;

  assign rd_val = ram_rdata[VAL_W-1:0];
  assign rd_cnt = ram_rdata[ENT_W-1:VAL_W];

  bpv_ram #(
    .WIDTH (ENT_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  // Shared comparator: the latched vote in the range test, else the entry read
  assign eval_val = (state_r == S_CHK) ? vote_r : rd_val;

  bpv_eval u_eval (
    .val (eval_val),
    .key (vote_r),
    .tgt (tgt_r),
    .lo  (lo_r),
    .hi  (hi_r),
    .res (ev)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign slot_free  = !out_valid_r || out_tready;
  assign more       = (USED_W'(idx_r) + USED_W'(1)) < used_r;

  // Clip the winning count to the 16-bit result field
  assign best_wide = WIDE_W'(best_c_r);
  assign win_cnt   = (best_wide > WIDE_W'({WIN_W{1'b1}})) ? {WIN_W{1'b1}}
                                                          : best_wide[WIN_W-1:0];

  // Plurality rule: higher count wins, equal nonzero count goes to smaller value
  always_comb begin
    take = cand_ok_r && ((cand_c_r > best_c_r) ||
                         ((cand_c_r == best_c_r) && (cand_c_r != '0) &&
                          (cand_v_r < best_v_r)));
  end

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    tgt_nxt       = tgt_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    vote_nxt      = vote_r;
    used_nxt      = used_r;
    ovf_nxt       = ovf_r;
    idx_nxt       = idx_r;
    best_v_nxt    = best_v_r;
    best_c_nxt    = best_c_r;
    seen_nxt      = seen_r;
    cand_v_nxt    = cand_v_r;
    cand_c_nxt    = cand_c_r;
    cand_ok_nxt   = cand_ok_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = idx_r;
    ram_wdata     = {sat_inc(rd_cnt), rd_val};

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_valid) begin
      unique case (cfg_index)
        REG_CURRENT: cur_nxt = cfg_data;
        REG_TARGET:  tgt_nxt = cfg_data;
        default:     ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          // Snapshot the range bounds for the whole item
          lo_nxt     = (cur_r < tgt_r) ? cur_r : tgt_r;
          hi_nxt     = (cur_r < tgt_r) ? tgt_r : cur_r;
          vote_nxt   = (in_tuser == CMD_ABSTAIN) ? cur_r : in_tdata;
          idx_nxt    = '0;
          best_v_nxt = cur_r;
          best_c_nxt = '0;
          seen_nxt   = 1'b0;
          priority if (in_tuser == CMD_VOTE || in_tuser == CMD_ABSTAIN) begin
            state_nxt = S_CHK;
          end else if (in_tuser == CMD_DECIDE) begin
            state_nxt = (used_r == '0) ? S_TGT : S_RD;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_CHK: begin
        // Drop an out-of-range vote without a flag
        priority if (!ev.in_range) begin
          state_nxt = S_IDLE;
        end else if (used_r == '0) begin
          state_nxt = S_APND;
        end else begin
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        state_nxt = dec_r ? S_DCHK : S_VCMP;
      end
      S_VCMP: begin
        priority if (ev.key_hit) begin
          ram_we    = 1'b1;
          state_nxt = S_IDLE;
        end else if (more) begin
          idx_nxt   = idx_r + IDX_W'(1);
          state_nxt = S_RD;
        end else begin
          state_nxt = S_APND;
        end
      end
      S_APND: begin
        if (used_r < USED_FULL) begin
          ram_we    = 1'b1;
          ram_waddr = used_r[IDX_W-1:0];
          ram_wdata = {CNT_ONE, vote_r};
          used_nxt  = used_r + USED_W'(1);
        end else begin
          ovf_nxt = 1'b1;
        end
        state_nxt = S_IDLE;
      end
      S_DCHK: begin
        cand_v_nxt  = rd_val;
        cand_ok_nxt = ev.in_range;
        cand_c_nxt  = ev.tgt_hit ? sat_inc(rd_cnt) : rd_cnt;
        if (ev.in_range && ev.tgt_hit) begin
          seen_nxt = 1'b1;
        end
        state_nxt = S_DCON;
      end
      S_DCON: begin
        if (take) begin
          best_v_nxt = cand_v_r;
          best_c_nxt = cand_c_r;
        end
        if (more) begin
          idx_nxt   = idx_r + IDX_W'(1);
          state_nxt = S_RD;
        end else begin
          state_nxt = S_TGT;
        end
      end
      S_TGT: begin
        // Implicit target vote when the table never held the target
        if (!seen_r && ((best_c_r < CNT_ONE) ||
                        ((best_c_r == CNT_ONE) && (tgt_r < best_v_r)))) begin
          best_v_nxt = tgt_r;
          best_c_nxt = CNT_ONE;
        end
        state_nxt = S_FIN;
      end
      S_FIN: begin
        // Hold until the result register is free, then empty the table
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {6'd0, ovf_r, (best_v_r != cur_r), win_cnt, best_v_r};
          used_nxt      = '0;
          ovf_nxt       = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Mode bit: set for a decide walk, clear for a vote search
  always_comb begin
    dec_nxt = dec_r;
    if (in_xfer) begin
      dec_nxt = (in_tuser == CMD_DECIDE);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cur_r       <= '0;
      tgt_r       <= '0;
      used_r      <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
      dec_r       <= 1'b0;
      cand_ok_r   <= 1'b0;
      best_c_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      tgt_r       <= tgt_nxt;
      used_r      <= used_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
      dec_r       <= dec_nxt;
      cand_ok_r   <= cand_ok_nxt;
      best_c_r    <= best_c_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    vote_r     <= vote_nxt;
    idx_r      <= idx_nxt;
    best_v_r   <= best_v_nxt;
    seen_r     <= seen_nxt;
    cand_v_r   <= cand_v_nxt;
    cand_c_r   <= cand_c_nxt;
    out_data_r <= out_data_nxt;
  end

`ifndef SYNTHESIS
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= USED_FULL)
    else $error("fill count beyond table depth");

  a_clear_after_decide: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && slot_free) |=> (used_r == '0 && !ovf_r && out_valid_r))
    else $error("table not cleared or result missing after decide");

  a_winner_counted: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN) |-> (best_c_r != '0))
    else $error("decide finished with a zero winning count");
`endif

endmodule
`default_nettype wire
